// File: hdl/text_and_jpeg_stream_splitter_defines.svh
// ----------------------------------------------------------------------------
// text and jpeg stream splitter assertion macros
// shared property forms for the splitter checks
// ----------------------------------------------------------------------------
`ifndef TEXT_AND_JPEG_STREAM_SPLITTER_DEFINES_SVH
`define TEXT_AND_JPEG_STREAM_SPLITTER_DEFINES_SVH

// antecedent implies consequent on the same edge
`define TJS_ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// condition never holds
`define TJS_ASSERT_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

`endif

// File: hdl/tjs_pkg.sv
// ----------------------------------------------------------------------------
// tjs_pkg
// shared types, constants and character helpers of the stream splitter
// ----------------------------------------------------------------------------
package tjs_pkg;

   localparam int BYTE_BITS        = 8;
   localparam int LEN_BITS         = 24;
   localparam int FRAME_COUNT_BITS = 32;
   localparam int FRAMES_DONE_BITS = 32;
   localparam int MARK_LEN         = 11;
   localparam int POS_BITS         = 4;

   localparam logic [LEN_BITS-1:0]  LEN_MAX         = '1;
   localparam logic [LEN_BITS-1:0]  RESET_MAX_IMAGE = 24'd10485760;
   localparam logic [POS_BITS-1:0]  MARK_LEN_POS    = POS_BITS'(MARK_LEN);

   localparam logic [BYTE_BITS-1:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [BYTE_BITS-1:0] CHAR_TAB     = 8'h09;
   localparam logic [BYTE_BITS-1:0] CHAR_VTAB    = 8'h0B;
   localparam logic [BYTE_BITS-1:0] CHAR_FFEED   = 8'h0C;
   localparam logic [BYTE_BITS-1:0] CHAR_CR      = 8'h0D;
   localparam logic [BYTE_BITS-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [BYTE_BITS-1:0] JPEG_PREFIX  = 8'hFF;
   localparam logic [BYTE_BITS-1:0] JPEG_EOI     = 8'hD9;

   // byte held in the input register
   typedef struct packed {
      logic                 valid;
      logic [BYTE_BITS-1:0] rx_byte;
   } item_type;

   // one result item
   typedef struct packed {
      logic                        byte_class;
      logic [BYTE_BITS-1:0]        data_out;
      logic                        line_end;
      logic                        line_not_blank;
      logic                        marker_seen;
      logic                        image_end;
      logic                        overflow;
      logic [FRAMES_DONE_BITS-1:0] frames_done;
   } result_type;

   // "ACK IMG END"
   function automatic logic [BYTE_BITS-1:0] mark_char(input logic [POS_BITS-1:0] pos);
      logic [BYTE_BITS-1:0] ch;
      case (pos)
         4'd0:    ch = 8'h41;
         4'd1:    ch = 8'h43;
         4'd2:    ch = 8'h4B;
         4'd3:    ch = 8'h20;
         4'd4:    ch = 8'h49;
         4'd5:    ch = 8'h4D;
         4'd6:    ch = 8'h47;
         4'd7:    ch = 8'h20;
         4'd8:    ch = 8'h45;
         4'd9:    ch = 8'h4E;
         4'd10:   ch = 8'h44;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic is_blank(input logic [BYTE_BITS-1:0] c);
      return c inside {CHAR_SPACE, CHAR_TAB, CHAR_NEWLINE, CHAR_VTAB, CHAR_FFEED, CHAR_CR};
   endfunction

endpackage

// File: hdl/tjs_in_stage.sv
// ----------------------------------------------------------------------------
// tjs_in_stage
// input register of the splitter, takes one byte per cycle unless the held byte is stalled
// ----------------------------------------------------------------------------
module tjs_in_stage
   import tjs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [BYTE_BITS-1:0] req_rx_byte,
   input  logic                 advance,
   output item_type             item
);

   logic                 valid_ff, valid_in;
   logic [BYTE_BITS-1:0] byte_ff, byte_in;
   logic                 load;

   // free when empty or when the held byte moves on this cycle
   assign req_ready = !valid_ff || advance;
   assign load      = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (load) begin
         valid_in = 1'b1;
         byte_in  = req_rx_byte;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign item.valid   = valid_ff;
   assign item.rx_byte = byte_ff;

endmodule

// File: hdl/tjs_core.sv
// ----------------------------------------------------------------------------
// tjs_core
// line tracking, image counting and the byte limit register
// ----------------------------------------------------------------------------
module tjs_core
   import tjs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [LEN_BITS-1:0] csr_write_data,
   input  item_type            item,
   input  logic                advance,
   output result_type          result
);

   logic [LEN_BITS-1:0]         max_len_ff, max_len_in;
   logic                        in_image_ff, in_image_in;
   logic [POS_BITS-1:0]         pos_ff, pos_in;
   logic                        broken_ff, broken_in;
   logic                        saw_ff, saw_in;
   logic                        prev_ff_ff, prev_ff_in;
   logic [LEN_BITS-1:0]         len_ff, len_in;
   logic [FRAME_COUNT_BITS-1:0] frame_ff, frame_in;
   logic [LEN_BITS-1:0]         len_inc;
   logic [BYTE_BITS-1:0]        c;

   assign c       = item.rx_byte;
   assign len_inc = (len_ff != LEN_MAX) ? len_ff + 1'b1 : len_ff;
   assign max_len_in = csr_write_enable ? csr_write_data : max_len_ff;

   always_comb begin
      in_image_in = in_image_ff;
      pos_in      = pos_ff;
      broken_in   = broken_ff;
      saw_in      = saw_ff;
      prev_ff_in  = prev_ff_ff;
      len_in      = len_ff;
      frame_in    = frame_ff;

      result                = '0;
      result.data_out       = c;

      if (in_image_ff) begin
         result.byte_class = 1'b1;
         if (prev_ff_ff && c == JPEG_EOI) begin
            // end of image marker beats the limit
            result.image_end = 1'b1;
            frame_in    = frame_ff + 1'b1;
            in_image_in = 1'b0;
            len_in      = '0;
            prev_ff_in  = 1'b0;
            pos_in      = '0;
            broken_in   = 1'b0;
            saw_in      = 1'b0;
         end else if (len_inc > max_len_ff) begin
            result.overflow = 1'b1;
            in_image_in = 1'b0;
            len_in      = '0;
            prev_ff_in  = 1'b0;
            pos_in      = '0;
            broken_in   = 1'b0;
            saw_in      = 1'b0;
         end else begin
            len_in     = len_inc;
            prev_ff_in = (c == JPEG_PREFIX);
         end
      end else if (c == CHAR_NEWLINE) begin
         result.line_end       = 1'b1;
         result.line_not_blank = saw_ff;
         result.marker_seen    = (pos_ff >= MARK_LEN_POS) && !broken_ff;
         pos_in    = '0;
         broken_in = 1'b0;
         saw_in    = 1'b0;
         if (result.marker_seen) begin
            in_image_in = 1'b1;
            len_in      = '0;
            prev_ff_in  = 1'b0;
         end
      end else if (saw_ff || !is_blank(c)) begin
         saw_in = 1'b1;
         if (!broken_ff && pos_ff < MARK_LEN_POS) begin
            if (c == mark_char(pos_ff)) begin
               pos_in = pos_ff + 1'b1;
            end else begin
               broken_in = 1'b1;
            end
         end
      end

      result.frames_done = FRAMES_DONE_BITS'(frame_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= RESET_MAX_IMAGE;
      end else begin
         max_len_ff <= max_len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_image_ff <= 1'b0;
         pos_ff      <= '0;
         broken_ff   <= 1'b0;
         saw_ff      <= 1'b0;
         prev_ff_ff  <= 1'b0;
         len_ff      <= '0;
         frame_ff    <= '0;
      end else if (advance) begin
         in_image_ff <= in_image_in;
         pos_ff      <= pos_in;
         broken_ff   <= broken_in;
         saw_ff      <= saw_in;
         prev_ff_ff  <= prev_ff_in;
         len_ff      <= len_in;
         frame_ff    <= frame_in;
      end
   end

endmodule

// File: hdl/tjs_out_stage.sv
// ----------------------------------------------------------------------------
// tjs_out_stage
// result register of the splitter
// ----------------------------------------------------------------------------
module tjs_out_stage
   import tjs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type result,
   output logic       free,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output result_type rsp
);

   logic       valid_ff, valid_in;
   result_type rsp_ff, rsp_in;

   // empty, or the held result leaves this cycle
   assign free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      rsp_in   = rsp_ff;
      if (load) begin
         valid_in = 1'b1;
         rsp_in   = result;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp       = rsp_ff;

endmodule

// File: hdl/text_and_jpeg_stream_splitter.sv
// ----------------------------------------------------------------------------
// text_and_jpeg_stream_splitter
// splits a serial byte stream into text lines and jpeg image data
// ----------------------------------------------------------------------------
// one byte per transfer in, one result per transfer out, one byte per clock
// sustained while the receiver is ready; a taken byte is held in the input
// register, and the line and image state is updated as it moves into the
// result register, where rsp_valid marks it. a stalled receiver holds the
// result register; the input register still takes one more byte, then
// req_ready drops until the held result leaves. text lines that begin (after
// leading whitespace) with "ACK IMG END" switch to image mode; FF D9 or a
// byte count above csr_write_data's limit goes back to text mode. the limit
// resets to 10485760; the user must write it only while no byte is in
// flight, as the block itself does not enforce this.
`include "text_and_jpeg_stream_splitter_defines.svh"

module text_and_jpeg_stream_splitter
   import tjs_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   // byte input channel
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [BYTE_BITS-1:0]        req_rx_byte,
   // result channel
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_byte_class,
   output logic [BYTE_BITS-1:0]        rsp_data_out,
   output logic                        rsp_line_end,
   output logic                        rsp_line_not_blank,
   output logic                        rsp_marker_seen,
   output logic                        rsp_image_end,
   output logic                        rsp_overflow,
   output logic [FRAMES_DONE_BITS-1:0] rsp_frames_done,
   // image byte limit register
   input  logic                        csr_write_enable,
   input  logic [LEN_BITS-1:0]         csr_write_data
);

   item_type   item;
   result_type result;
   result_type rsp;
   logic       out_free;
   logic       advance;

   // a held byte moves on whenever the result register can take it
   assign advance = item.valid && out_free;

   tjs_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .advance     (advance),
      .item        (item)
   );

   // all per-byte decisions and the tracking state
   tjs_core u_core (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .item             (item),
      .advance          (advance),
      .result           (result)
   );

   tjs_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .result    (result),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   // unpack the result register onto the ports
   assign rsp_byte_class     = rsp.byte_class;
   assign rsp_data_out       = rsp.data_out;
   assign rsp_line_end       = rsp.line_end;
   assign rsp_line_not_blank = rsp.line_not_blank;
   assign rsp_marker_seen    = rsp.marker_seen;
   assign rsp_image_end      = rsp.image_end;
   assign rsp_overflow       = rsp.overflow;
   assign rsp_frames_done    = rsp.frames_done;

   // text results never carry image flags
   `TJS_ASSERT_IMPLIES(a_text_no_image_flags, rsp_valid && !rsp_byte_class, !rsp_image_end && !rsp_overflow, "image flag on a text byte")
   // line end only on a text newline
   `TJS_ASSERT_IMPLIES(a_line_end_newline, rsp_valid && rsp_line_end, !rsp_byte_class && rsp_data_out == CHAR_NEWLINE, "line end on a byte that is not a text newline")
   // a marker line is a non-blank line end
   `TJS_ASSERT_IMPLIES(a_marker_line, rsp_valid && rsp_marker_seen, rsp_line_end && rsp_line_not_blank, "marker seen without a non-blank line end")
   // end marker and overflow exclude each other
   `TJS_ASSERT_NEVER(a_end_or_overflow, rsp_valid && rsp_image_end && rsp_overflow, "image end and overflow on the same byte")

endmodule
